@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the histogrammer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

@@ hw/rtl/dhh_pkg.sv @@
// Types and constants shared by the hit histogrammer modules.
package dhh_pkg;

  localparam int unsigned OP_W        = 3;
  localparam int unsigned PLANE_W     = 2;
  localparam int unsigned STRIP_W     = 12;
  localparam int unsigned ADC_W       = 10;
  localparam int unsigned INTEGRAL_W  = 32;
  localparam int unsigned SEL_W       = 3;
  localparam int unsigned INDEX_W     = 12;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned BIN_WIDTH_W = 33;
  localparam int unsigned CFG_W       = 6;

  localparam logic [CFG_W-1:0] DOWNSHIFT_MAX = 6'd32;

  localparam logic [PLANE_W-1:0] PLANE_X = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_Y = 2'd1;

  // Bank positions inside the per-item increment vector.
  localparam int unsigned NUM_BANKS   = 5;
  localparam int unsigned B_X_STRIP   = 0;
  localparam int unsigned B_Y_STRIP   = 1;
  localparam int unsigned B_X_ADC     = 2;
  localparam int unsigned B_Y_ADC     = 3;
  localparam int unsigned B_CLUSTER   = 4;

  typedef enum logic [OP_W-1:0] {
    OP_SINGLE  = 3'd0,
    OP_PAIRED  = 3'd1,
    OP_CLUSTER = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_READ    = 3'd4
  } op_e;

  typedef enum logic [SEL_W-1:0] {
    HS_X_STRIP = 3'd0,
    HS_Y_STRIP = 3'd1,
    HS_X_ADC   = 3'd2,
    HS_Y_ADC   = 3'd3,
    HS_CLUSTER = 3'd4
  } hist_sel_e;

  // Per-cycle controls of one histogram bank.
  typedef struct packed {
    logic rd_en;
    logic inc;
    logic clr;
  } bank_ctrl_t;

endpackage

@@ hw/rtl/dhh_hist_bank.sv @@
// One histogram bank: count memory with read, increment write-back and clear.
module dhh_hist_bank #(
  parameter int unsigned ADDR_BITS  = 10,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                   clk_i,
  input  dhh_pkg::bank_ctrl_t    ctrl_i,
  input  logic [ADDR_BITS-1:0]   rd_addr_i,
  input  logic [ADDR_BITS-1:0]   clr_addr_i,
  output logic [COUNT_BITS-1:0]  rd_data_o
);
  import dhh_pkg::*;

  localparam int unsigned DEPTH = 1 << ADDR_BITS;

  logic [COUNT_BITS-1:0] mem_q [DEPTH];
  logic [ADDR_BITS-1:0]  addr_q;
  logic [COUNT_BITS-1:0] data_q;

  logic                  wr_en;
  logic [ADDR_BITS-1:0]  wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  // The increment writes back to the address read in the cycle before.
  always_comb begin
    wr_en   = ctrl_i.clr | ctrl_i.inc;
    wr_addr = ctrl_i.clr ? clr_addr_i : addr_q;
    wr_data = ctrl_i.clr ? '0 : data_q + COUNT_BITS'(1);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      addr_q <= rd_addr_i;
      data_q <= mem_q[rd_addr_i];
    end
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  assign rd_data_o = data_q;

endmodule

@@ hw/rtl/detector_hit_histogrammer_core.sv @@
// Top level of the detector hit histogrammer.
//
// Five count histograms (X and Y strip, X and Y ADC, cluster charge) live in
// single-port-per-side memories and are updated by read, increment and write
// back. An item is taken when start_i is high and busy_o is low and occupies
// the block through one memory read and then one write-back, so a new item
// is taken only once the last is through. Its result appears on the result
// ports for one cycle, marked by done_o, in the cycle after the write-back;
// the receiver cannot stall it. A clear item walks every bin of the largest
// histogram, all 2^max(STRIP_BITS, ADC_BITS) bins (4096 by default), and its
// result follows the last bin. After reset the same clearing pass runs with
// busy_o high and gives no result; configuration writes are taken throughout.
module detector_hit_histogrammer_core #(
  parameter int unsigned STRIP_BITS = 12,
  parameter int unsigned ADC_BITS   = 10,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [dhh_pkg::OP_W-1:0]           operation_i,
  input  logic [dhh_pkg::PLANE_W-1:0]        plane_i,
  input  logic [dhh_pkg::STRIP_W-1:0]        strip_i,
  input  logic [dhh_pkg::ADC_W-1:0]          adc_i,
  input  logic [dhh_pkg::STRIP_W-1:0]        y_strip_i,
  input  logic [dhh_pkg::ADC_W-1:0]          y_adc_i,
  input  logic [dhh_pkg::INTEGRAL_W-1:0]     x_integral_i,
  input  logic [dhh_pkg::INTEGRAL_W-1:0]     y_integral_i,
  input  logic [dhh_pkg::SEL_W-1:0]          hist_select_i,
  input  logic [dhh_pkg::INDEX_W-1:0]        read_index_i,
  input  logic                               cfg_we_i,
  input  logic [dhh_pkg::CFG_W-1:0]          cfg_wdata_i,
  output logic                               done_o,
  output logic [dhh_pkg::TOTAL_W-1:0]        read_count_o,
  output logic [dhh_pkg::TOTAL_W-1:0]        hit_total_o,
  output logic [dhh_pkg::TOTAL_W-1:0]        cluster_total_o,
  output logic                               is_empty_o,
  output logic [dhh_pkg::BIN_WIDTH_W-1:0]    bin_width_o
);
  import dhh_pkg::*;

  localparam int unsigned SWEEP_BITS = (STRIP_BITS > ADC_BITS) ? STRIP_BITS : ADC_BITS;
  localparam logic [31:0] STRIP_LAST = 32'((1 << STRIP_BITS) - 1);
  localparam logic [31:0] ADC_LAST   = 32'((1 << ADC_BITS) - 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_UPDATE = 3'b010,
    S_CLEAR  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic                  accept;
  logic [CFG_W-1:0]      downshift_q;
  logic [SWEEP_BITS-1:0] clr_addr_q;
  logic                  report_q;

  // Item registers, loaded on acceptance.
  logic [NUM_BANKS-1:0]  inc_q, inc_d;
  logic                  hit_inc_q, hit_inc_d;
  logic                  cl_inc_q, cl_inc_d;
  logic                  read_q;
  logic [SEL_W-1:0]      sel_q;
  logic                  oor_q, oor_d;

  logic [TOTAL_W-1:0]    hits_q, hits_d;
  logic [TOTAL_W-1:0]    clus_q, clus_d;
  logic                  done_d;

  logic                  done_q;
  logic [TOTAL_W-1:0]    read_count_q;
  logic [TOTAL_W-1:0]    hit_total_q;
  logic [TOTAL_W-1:0]    cluster_total_q;
  logic                  is_empty_q;
  logic [BIN_WIDTH_W-1:0] bin_width_q;

  // Bin index arithmetic.
  logic [31:0] strip_w, y_strip_w, adc_w, y_adc_w, ridx_w;
  logic [INTEGRAL_W-1:0] cl_sum, cl_shift;
  logic [STRIP_BITS-1:0] strip_ix, y_strip_ix, xs_addr, ys_addr;
  logic [ADC_BITS-1:0]   adc_ix, y_adc_ix, cl_ix, xa_addr, ya_addr, cl_addr;

  bank_ctrl_t            ctrl [NUM_BANKS];
  logic [COUNT_BITS-1:0] xs_data, ys_data, xa_data, ya_data, cl_data, rd_sel;
  logic [63:0]           rd_wide;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  assign strip_w   = 32'(strip_i);
  assign y_strip_w = 32'(y_strip_i);
  assign adc_w     = 32'(adc_i);
  assign y_adc_w   = 32'(y_adc_i);
  assign ridx_w    = 32'(read_index_i);
  assign cl_sum    = x_integral_i + y_integral_i;
  assign cl_shift  = cl_sum >> downshift_q;

  // Indices past the last bin land in the last bin.
  assign strip_ix   = (strip_w > STRIP_LAST) ? STRIP_LAST[STRIP_BITS-1:0]
                                             : strip_w[STRIP_BITS-1:0];
  assign y_strip_ix = (y_strip_w > STRIP_LAST) ? STRIP_LAST[STRIP_BITS-1:0]
                                               : y_strip_w[STRIP_BITS-1:0];
  assign adc_ix     = (adc_w > ADC_LAST) ? ADC_LAST[ADC_BITS-1:0] : adc_w[ADC_BITS-1:0];
  assign y_adc_ix   = (y_adc_w > ADC_LAST) ? ADC_LAST[ADC_BITS-1:0] : y_adc_w[ADC_BITS-1:0];
  assign cl_ix      = (cl_shift > ADC_LAST) ? ADC_LAST[ADC_BITS-1:0] : cl_shift[ADC_BITS-1:0];

  always_comb begin
    xs_addr = strip_ix;
    ys_addr = strip_ix;
    xa_addr = adc_ix;
    ya_addr = adc_ix;
    cl_addr = cl_ix;
    if (operation_i == OP_PAIRED) begin
      ys_addr = y_strip_ix;
      ya_addr = y_adc_ix;
    end else if (operation_i == OP_READ) begin
      xs_addr = ridx_w[STRIP_BITS-1:0];
      ys_addr = ridx_w[STRIP_BITS-1:0];
      xa_addr = ridx_w[ADC_BITS-1:0];
      ya_addr = ridx_w[ADC_BITS-1:0];
      cl_addr = ridx_w[ADC_BITS-1:0];
    end
  end

  // Decode which banks and totals an item bumps.
  always_comb begin
    inc_d     = '0;
    hit_inc_d = 1'b0;
    cl_inc_d  = 1'b0;
    unique case (operation_i)
      OP_SINGLE: begin
        if (plane_i == PLANE_X) begin
          inc_d[B_X_STRIP] = 1'b1;
          inc_d[B_X_ADC]   = 1'b1;
          hit_inc_d        = 1'b1;
        end else if (plane_i == PLANE_Y) begin
          inc_d[B_Y_STRIP] = 1'b1;
          inc_d[B_Y_ADC]   = 1'b1;
          hit_inc_d        = 1'b1;
        end
      end
      OP_PAIRED: begin
        inc_d[B_X_STRIP] = 1'b1;
        inc_d[B_X_ADC]   = 1'b1;
        inc_d[B_Y_STRIP] = 1'b1;
        inc_d[B_Y_ADC]   = 1'b1;
        hit_inc_d        = 1'b1;
      end
      OP_CLUSTER: begin
        if (cl_sum != '0) begin
          inc_d[B_CLUSTER] = 1'b1;
          cl_inc_d         = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (hist_select_i)
      HS_X_STRIP, HS_Y_STRIP:         oor_d = (ridx_w > STRIP_LAST);
      HS_X_ADC, HS_Y_ADC, HS_CLUSTER: oor_d = (ridx_w > ADC_LAST);
      default:                        oor_d = 1'b1;
    endcase
  end

  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      ctrl[b].rd_en = accept;
      ctrl[b].inc   = (state_q == S_UPDATE) && inc_q[b];
      ctrl[b].clr   = (state_q == S_CLEAR);
    end
  end

  dhh_hist_bank #(.ADDR_BITS(STRIP_BITS), .COUNT_BITS(COUNT_BITS)) u_x_strip (
    .clk_i, .ctrl_i(ctrl[B_X_STRIP]), .rd_addr_i(xs_addr),
    .clr_addr_i(clr_addr_q[STRIP_BITS-1:0]), .rd_data_o(xs_data)
  );
  dhh_hist_bank #(.ADDR_BITS(STRIP_BITS), .COUNT_BITS(COUNT_BITS)) u_y_strip (
    .clk_i, .ctrl_i(ctrl[B_Y_STRIP]), .rd_addr_i(ys_addr),
    .clr_addr_i(clr_addr_q[STRIP_BITS-1:0]), .rd_data_o(ys_data)
  );
  dhh_hist_bank #(.ADDR_BITS(ADC_BITS), .COUNT_BITS(COUNT_BITS)) u_x_adc (
    .clk_i, .ctrl_i(ctrl[B_X_ADC]), .rd_addr_i(xa_addr),
    .clr_addr_i(clr_addr_q[ADC_BITS-1:0]), .rd_data_o(xa_data)
  );
  dhh_hist_bank #(.ADDR_BITS(ADC_BITS), .COUNT_BITS(COUNT_BITS)) u_y_adc (
    .clk_i, .ctrl_i(ctrl[B_Y_ADC]), .rd_addr_i(ya_addr),
    .clr_addr_i(clr_addr_q[ADC_BITS-1:0]), .rd_data_o(ya_data)
  );
  dhh_hist_bank #(.ADDR_BITS(ADC_BITS), .COUNT_BITS(COUNT_BITS)) u_cluster (
    .clk_i, .ctrl_i(ctrl[B_CLUSTER]), .rd_addr_i(cl_addr),
    .clr_addr_i(clr_addr_q[ADC_BITS-1:0]), .rd_data_o(cl_data)
  );

  always_comb begin
    case (sel_q)
      HS_X_STRIP: rd_sel = xs_data;
      HS_Y_STRIP: rd_sel = ys_data;
      HS_X_ADC:   rd_sel = xa_data;
      HS_Y_ADC:   rd_sel = ya_data;
      HS_CLUSTER: rd_sel = cl_data;
      default:    rd_sel = '0;
    endcase
    rd_wide = (read_q && !oor_q) ? 64'(rd_sel) : 64'd0;
  end

  // Sequencer: totals follow the write-back, results follow the totals.
  always_comb begin
    state_d = state_q;
    hits_d  = hits_q;
    clus_d  = clus_q;
    done_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (operation_i == OP_CLEAR) begin
            state_d = S_CLEAR;
            hits_d  = '0;
            clus_d  = '0;
          end else begin
            state_d = S_UPDATE;
          end
        end
      end
      S_UPDATE: begin
        hits_d  = hits_q + TOTAL_W'(hit_inc_q);
        clus_d  = clus_q + TOTAL_W'(cl_inc_q);
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_CLEAR: begin
        if (clr_addr_q == '1) begin
          state_d = S_IDLE;
          done_d  = report_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      report_q    <= 1'b0;
      hits_q      <= '0;
      clus_q      <= '0;
      downshift_q <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      hits_q  <= hits_d;
      clus_q  <= clus_d;
      done_q  <= done_d;
      if (state_q == S_CLEAR) begin
        clr_addr_q <= clr_addr_q + SWEEP_BITS'(1);
      end
      if (accept && (operation_i == OP_CLEAR)) begin
        report_q <= 1'b1;
      end
      if (cfg_we_i) begin
        downshift_q <= (cfg_wdata_i > DOWNSHIFT_MAX) ? DOWNSHIFT_MAX : cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      inc_q     <= inc_d;
      hit_inc_q <= hit_inc_d;
      cl_inc_q  <= cl_inc_d;
      read_q    <= (operation_i == OP_READ);
      sel_q     <= hist_select_i;
      oor_q     <= oor_d;
    end
    if (done_d) begin
      read_count_q    <= rd_wide[TOTAL_W-1:0];
      hit_total_q     <= hits_d;
      cluster_total_q <= clus_d;
      is_empty_q      <= (hits_d == '0) && (clus_d == '0);
      bin_width_q     <= BIN_WIDTH_W'(1) << downshift_q;
    end
  end

  assign done_o          = done_q;
  assign read_count_o    = read_count_q;
  assign hit_total_o     = hit_total_q;
  assign cluster_total_o = cluster_total_q;
  assign is_empty_o      = is_empty_q;
  assign bin_width_o     = bin_width_q;

endmodule

@@ hw/rtl/dhh_checker.sv @@
// Port-level checks of the hit histogrammer and their binding to the top level.
`include "assert_macros.svh"

module dhh_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start_i,
  input logic                               busy_o,
  input logic                               done_o,
  input logic [dhh_pkg::TOTAL_W-1:0]        hit_total_o,
  input logic [dhh_pkg::TOTAL_W-1:0]        cluster_total_o,
  input logic                               is_empty_o,
  input logic [dhh_pkg::BIN_WIDTH_W-1:0]    bin_width_o
);
  import dhh_pkg::*;

  // Every accepted beat keeps the block busy for at least the next cycle.
  `ASSERT_NEXT(accept_then_busy, start_i && !busy_o, busy_o)
  // Results are never shown in two consecutive cycles.
  `ASSERT_NEXT(done_single_cycle, done_o, !done_o)
  // A result is shown only once the block has gone idle.
  `ASSERT_IMPL(done_when_idle, done_o, !busy_o)
  `ASSERT_IMPL(empty_matches_totals, done_o,
               is_empty_o == ((hit_total_o == '0) && (cluster_total_o == '0)))
  `ASSERT_IMPL(bin_width_power_of_two, done_o, $onehot(bin_width_o))

endmodule

bind detector_hit_histogrammer_core dhh_checker u_dhh_checker (.*);
